// ===== src/fpba_pkg.sv =====
// Shared types and constants for the fit-policy block allocator.
// Depends on nothing; the top level refers to it by scoped names.
package fpba_pkg;

    localparam int CMD_W        = 1;
    localparam int SLOT_W       = 4;
    localparam int SIZE_W       = 16;
    localparam int REQ_NUM_W    = 16;
    localparam int GRANT_IDX_W  = 4;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 24;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 8;
    localparam int MODE_W       = 2;
    localparam int BLK_COUNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 1'b0;
    localparam logic [CMD_W-1:0] CMD_REQUEST = 1'b1;

    localparam logic [MODE_W-1:0] MODE_FIRST_FIT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST_FIT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST_FIT = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_FIT_MODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 2'd1;

    localparam logic [BLK_COUNT_W-1:0] BLOCK_COUNT_RESET = 5'd16;

endpackage

// ===== src/fit_policy_block_allocator.sv =====
// Top level of the fit-policy block allocator: size table, scan sequencer and stream ports.
// Depends on fpba_pkg for field widths, command codes, fit modes and register indexes.
//
// A load word (tuser 0) writes one table entry; the block stays idle and is ready again in
// the next cycle. A request word (tuser 1) is served by a single comparator that walks the table
// one entry per cycle through a registered memory read, over min(block_count, NUM_BLOCKS) entries,
// stopping early under first fit when a block is found. The result waits in an
// output register, and the next word is accepted while it waits. Each entry has a valid bit that
// reset clears, so no clearing pass is needed after reset.
module fit_policy_block_allocator #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fpba_pkg::S_TDATA_W-1:0]      s_tdata,  // block_slot[3:0], size_value[19:4]
    input  logic [fpba_pkg::CMD_W-1:0]          s_tuser,  // cmd[0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fpba_pkg::M_TDATA_W-1:0]      m_tdata,  // request_number[15:0], granted_block[19:16]
    output logic                                m_tuser,  // granted[0]
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fpba_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int LIM_W = (CNT_W > fpba_pkg::BLK_COUNT_W) ? CNT_W : fpba_pkg::BLK_COUNT_W;
    localparam int SLW   = (CNT_W > fpba_pkg::SLOT_W) ? CNT_W : fpba_pkg::SLOT_W;
    localparam int CW    = (SIZE_BITS > fpba_pkg::SIZE_W) ? SIZE_BITS : fpba_pkg::SIZE_W;
    localparam int GW    = (IDX_W > fpba_pkg::GRANT_IDX_W) ? IDX_W : fpba_pkg::GRANT_IDX_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_GRANT
    } state_t;

    state_t                              state_reg;
    logic [fpba_pkg::MODE_W-1:0]         fit_mode_reg;
    logic [fpba_pkg::BLK_COUNT_W-1:0]    block_count_reg;
    logic [fpba_pkg::REQ_NUM_W-1:0]      req_count_reg;
    logic [NUM_BLOCKS-1:0]               valid_reg;
    logic [CNT_W-1:0]                    idx_reg;
    logic [CNT_W-1:0]                    limit_reg;
    logic [CW-1:0]                       want_reg;
    logic                                cmp_vld_reg;
    logic [IDX_W-1:0]                    cmp_idx_reg;
    logic                                found_reg;
    logic [IDX_W-1:0]                    best_idx_reg;
    logic [SIZE_BITS-1:0]                best_size_reg;
    logic                                m_tvalid_reg;
    logic [fpba_pkg::REQ_NUM_W-1:0]      out_num_reg;
    logic                                out_granted_reg;
    logic [fpba_pkg::GRANT_IDX_W-1:0]    out_block_reg;

    logic [SIZE_BITS-1:0]                mem [NUM_BLOCKS];
    logic [SIZE_BITS-1:0]                rdata_reg;
    logic                                rvalid_bit_reg;

    logic [fpba_pkg::SLOT_W-1:0]         in_slot;
    logic [fpba_pkg::SIZE_W-1:0]         in_size;
    logic [SLW-1:0]                      slot_ext;
    logic                                slot_ok;
    logic [CW-1:0]                       load_ext;
    logic [SIZE_BITS-1:0]                load_data;
    logic                                wr_en;
    logic [IDX_W-1:0]                    wr_addr;
    logic                                in_accept;
    logic [LIM_W-1:0]                    bc_ext;
    logic [LIM_W-1:0]                    lim_full;
    logic [CNT_W-1:0]                    lim_next;
    logic [CW-1:0]                       want_next;
    logic                                rd_en;
    logic [IDX_W-1:0]                    rd_addr;
    logic [CW-1:0]                       eff;
    logic [CW-1:0]                       best_ext;
    logic                                is_best;
    logic                                is_worst;
    logic                                take;
    logic                                first_stop;
    logic                                scan_end;
    logic                                out_free;
    logic [GW-1:0]                       best_idx_ext;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;
    assign in_slot   = s_tdata[fpba_pkg::SLOT_W-1:0];
    assign in_size   = s_tdata[fpba_pkg::SLOT_W+fpba_pkg::SIZE_W-1:fpba_pkg::SLOT_W];

    assign slot_ext  = SLW'(in_slot);
    assign slot_ok   = slot_ext < SLW'(NUM_BLOCKS);
    assign load_ext  = CW'(in_size);
    assign load_data = load_ext[SIZE_BITS-1:0];
    assign wr_addr   = slot_ext[IDX_W-1:0];
    assign wr_en     = in_accept && (s_tuser == fpba_pkg::CMD_LOAD) && slot_ok;

    assign bc_ext    = LIM_W'(block_count_reg);
    assign lim_full  = (bc_ext > LIM_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS) : bc_ext;
    assign lim_next  = lim_full[CNT_W-1:0];
    assign want_next = (in_size == '0) ? CW'(1) : CW'(in_size);

    assign is_best    = (fit_mode_reg == fpba_pkg::MODE_BEST_FIT);
    assign is_worst   = (fit_mode_reg == fpba_pkg::MODE_WORST_FIT);
    assign eff        = rvalid_bit_reg ? CW'(rdata_reg) : '0;
    assign best_ext   = CW'(best_size_reg);
    assign take       = cmp_vld_reg && (eff >= want_reg)
                        && (!found_reg || (is_best && (eff < best_ext))
                            || (is_worst && (eff > best_ext)));
    assign first_stop = take && !is_best && !is_worst;
    assign scan_end   = first_stop || (idx_reg == limit_reg);
    assign rd_en      = (state_reg == ST_SCAN) && !scan_end;
    assign rd_addr    = idx_reg[IDX_W-1:0];
    assign out_free   = !m_tvalid_reg || m_tready;
    assign best_idx_ext = GW'(best_idx_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_granted_reg;
    assign m_tdata  = fpba_pkg::M_TDATA_W'({out_block_reg, out_num_reg});

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= load_data;
        end
        if (rd_en)
        begin
            rdata_reg      <= mem[rd_addr];
            rvalid_bit_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            fit_mode_reg    <= fpba_pkg::MODE_FIRST_FIT;
            block_count_reg <= fpba_pkg::BLOCK_COUNT_RESET;
            req_count_reg   <= '0;
            valid_reg       <= '0;
            idx_reg         <= '0;
            limit_reg       <= '0;
            want_reg        <= '0;
            cmp_vld_reg     <= 1'b0;
            cmp_idx_reg     <= '0;
            found_reg       <= 1'b0;
            best_idx_reg    <= '0;
            best_size_reg   <= '0;
            m_tvalid_reg    <= 1'b0;
            out_num_reg     <= '0;
            out_granted_reg <= 1'b0;
            out_block_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    fpba_pkg::REG_FIT_MODE:    fit_mode_reg    <= cfg_data[fpba_pkg::MODE_W-1:0];
                    fpba_pkg::REG_BLOCK_COUNT: block_count_reg <= cfg_data[fpba_pkg::BLK_COUNT_W-1:0];
                    default:                   ;
                endcase
            end

            if (m_tready && (state_reg != ST_GRANT))
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (wr_en)
                    begin
                        valid_reg[wr_addr] <= 1'b1;
                    end
                    if (in_accept && (s_tuser == fpba_pkg::CMD_REQUEST))
                    begin
                        req_count_reg <= req_count_reg + 1'b1;
                        limit_reg     <= lim_next;
                        want_reg      <= want_next;
                        idx_reg       <= '0;
                        cmp_vld_reg   <= 1'b0;
                        found_reg     <= 1'b0;
                        best_idx_reg  <= '0;
                        best_size_reg <= '0;
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (take)
                    begin
                        found_reg     <= 1'b1;
                        best_idx_reg  <= cmp_idx_reg;
                        best_size_reg <= eff[SIZE_BITS-1:0];
                    end
                    if (scan_end)
                    begin
                        cmp_vld_reg <= 1'b0;
                        state_reg   <= ST_GRANT;
                    end
                    else
                    begin
                        cmp_vld_reg <= 1'b1;
                        cmp_idx_reg <= rd_addr;
                        idx_reg     <= idx_reg + 1'b1;
                    end
                end
                ST_GRANT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg    <= 1'b1;
                        out_num_reg     <= req_count_reg;
                        out_granted_reg <= found_reg;
                        out_block_reg   <= found_reg
                                           ? best_idx_ext[fpba_pkg::GRANT_IDX_W-1:0] : '0;
                        if (found_reg)
                        begin
                            valid_reg[best_idx_reg] <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for fit_policy_block_allocator: directed table, then random phases.
// Depends on fpba_pkg and the allocator RTL; results are predicted by a model of the free table.
module tb;

    localparam int TABLE_DEPTH = 16;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT = 300000;
    localparam logic [fpba_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [fpba_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [fpba_pkg::REQ_NUM_W-1:0]   num;
        logic                             granted;
        logic [fpba_pkg::GRANT_IDX_W-1:0] blk;
    } alloc_result_t;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                        kind;
        logic [fpba_pkg::CMD_W-1:0]       cmd;
        logic [fpba_pkg::SLOT_W-1:0]      slot;
        logic [fpba_pkg::SIZE_W-1:0]      size;
        logic [fpba_pkg::CFG_INDEX_W-1:0] reg_idx;
        logic [fpba_pkg::CFG_DATA_W-1:0]  reg_data;
        logic                             typed;
        alloc_result_t                    typed_res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [fpba_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [fpba_pkg::CMD_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [fpba_pkg::M_TDATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [fpba_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic [fpba_pkg::SIZE_W-1:0] free_sz [TABLE_DEPTH];
    logic [fpba_pkg::REQ_NUM_W-1:0] req_cnt;
    logic [fpba_pkg::MODE_W-1:0] fit_mode_q;
    logic [fpba_pkg::BLK_COUNT_W-1:0] blk_cnt_q;

    alloc_result_t results_due[$];
    stim_row_t dir_rows[$];
    int mismatch_count = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_left = 0;
    int cycle_count = 0;

    fit_policy_block_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        alloc_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (results_due.size() == 0)
            begin
                report_mismatch("unexpected word, request_number", int'(m_tdata[15:0]), -1);
            end
            else
            begin
                want = results_due.pop_front();
                if (m_tdata[15:0] !== want.num)
                    report_mismatch("request_number", int'(m_tdata[15:0]), int'(want.num));
                if (m_tuser !== want.granted)
                    report_mismatch("granted", int'(m_tuser), int'(want.granted));
                if (m_tdata[19:16] !== want.blk)
                    report_mismatch("granted_block", int'(m_tdata[19:16]), int'(want.blk));
            end
        end
    end

    function automatic void reset_table();
        for (int j = 0; j < TABLE_DEPTH; j++)
            free_sz[j] = '0;
        req_cnt = '0;
        fit_mode_q = fpba_pkg::MODE_FIRST_FIT;
        blk_cnt_q = fpba_pkg::BLOCK_COUNT_RESET;
    endfunction

    // Applies one word to the table model; returns 1 when the word yields a result.
    function automatic bit serve_word(input logic [fpba_pkg::CMD_W-1:0] cmd,
                                      input logic [fpba_pkg::SLOT_W-1:0] slot,
                                      input logic [fpba_pkg::SIZE_W-1:0] size,
                                      output alloc_result_t res);
        int lim;
        int pick;
        bit found;
        logic [fpba_pkg::SIZE_W-1:0] want;
        res = '0;
        if (cmd == fpba_pkg::CMD_LOAD)
        begin
            free_sz[slot] = size;
            return 1'b0;
        end
        req_cnt = req_cnt + 1'b1;
        lim = (blk_cnt_q > fpba_pkg::BLK_COUNT_W'(TABLE_DEPTH)) ? TABLE_DEPTH : int'(blk_cnt_q);
        want = (size == '0) ? fpba_pkg::SIZE_W'(1) : size;
        found = 1'b0;
        pick = 0;
        for (int j = 0; j < lim; j++)
        begin
            if (free_sz[j] >= want)
            begin
                if (!found)
                begin
                    found = 1'b1;
                    pick = j;
                    if (fit_mode_q != fpba_pkg::MODE_BEST_FIT
                        && fit_mode_q != fpba_pkg::MODE_WORST_FIT)
                        break;
                end
                else if (fit_mode_q == fpba_pkg::MODE_BEST_FIT && free_sz[j] < free_sz[pick])
                    pick = j;
                else if (fit_mode_q == fpba_pkg::MODE_WORST_FIT && free_sz[j] > free_sz[pick])
                    pick = j;
            end
        end
        if (found)
            free_sz[pick] = '0;
        res.num = req_cnt;
        res.granted = found;
        res.blk = found ? fpba_pkg::GRANT_IDX_W'(pick) : '0;
        return 1'b1;
    endfunction

    task automatic offer_word(input logic [fpba_pkg::CMD_W-1:0] cmd,
                              input logic [fpba_pkg::SLOT_W-1:0] slot,
                              input logic [fpba_pkg::SIZE_W-1:0] size, input bit typed,
                              input alloc_result_t typed_res);
        alloc_result_t res;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {4'd0, size, slot};
        do @(posedge clk); while (!s_tready);
        if (serve_word(cmd, slot, size, res))
            results_due.push_back(typed ? typed_res : res);
    endtask

    // Stops offering words and waits until the block has drained.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [fpba_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [fpba_pkg::CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == fpba_pkg::REG_FIT_MODE)
            fit_mode_q = d[fpba_pkg::MODE_W-1:0];
        else if (idx == fpba_pkg::REG_BLOCK_COUNT)
            blk_cnt_q = d[fpba_pkg::BLK_COUNT_W-1:0];
        @(posedge clk);
    endtask

    function automatic logic [fpba_pkg::SIZE_W-1:0] rand_size();
        case ($urandom_range(3))
            0: return fpba_pkg::SIZE_W'($urandom_range(15));
            1: return fpba_pkg::SIZE_W'($urandom_range(1023));
            2: return fpba_pkg::SIZE_W'($urandom);
            default: return 16'hFFFF - fpba_pkg::SIZE_W'($urandom_range(15));
        endcase
    endfunction

    task automatic run_phase(input logic [fpba_pkg::CFG_DATA_W-1:0] mode_data,
                             input logic [fpba_pkg::CFG_DATA_W-1:0] count_data,
                             input int tx_pct, input int rx_pct, input int hold, input int n);
        logic [fpba_pkg::SIZE_W-1:0] size;
        settle();
        write_reg(fpba_pkg::REG_FIT_MODE, mode_data);
        write_reg(fpba_pkg::REG_BLOCK_COUNT, count_data);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        hold_left = hold;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 40)
            begin
                offer_word(fpba_pkg::CMD_LOAD, fpba_pkg::SLOT_W'($urandom_range(15)),
                           rand_size(), 1'b0, '0);
            end
            else
            begin
                // Half of the requests aim at a size already in the table.
                if ($urandom_range(1))
                begin
                    size = free_sz[$urandom_range(TABLE_DEPTH - 1)];
                    if ($urandom_range(1))
                        size = size - fpba_pkg::SIZE_W'($urandom_range(2));
                end
                else
                begin
                    size = rand_size();
                end
                offer_word(fpba_pkg::CMD_REQUEST, fpba_pkg::SLOT_W'($urandom), size, 1'b0, '0);
            end
        end
    endtask

    function automatic stim_row_t ld(input int slot, input int size);
        return '{ROW_WORD, fpba_pkg::CMD_LOAD, fpba_pkg::SLOT_W'(slot),
                 fpba_pkg::SIZE_W'(size), '0, '0, 1'b0, '0};
    endfunction

    function automatic stim_row_t rq(input int size);
        return '{ROW_WORD, fpba_pkg::CMD_REQUEST, '0, fpba_pkg::SIZE_W'(size), '0, '0, 1'b0, '0};
    endfunction

    function automatic stim_row_t rq_known(input int size, input int num, input bit g,
                                           input int blk);
        return '{ROW_WORD, fpba_pkg::CMD_REQUEST, '1, fpba_pkg::SIZE_W'(size), '0, '0, 1'b1,
                 '{fpba_pkg::REQ_NUM_W'(num), g, fpba_pkg::GRANT_IDX_W'(blk)}};
    endfunction

    function automatic stim_row_t wr(input logic [fpba_pkg::CFG_INDEX_W-1:0] idx, input int d);
        return '{ROW_CFG, fpba_pkg::CMD_LOAD, '0, '0, idx, fpba_pkg::CFG_DATA_W'(d), 1'b0, '0};
    endfunction

    initial
    begin : stimulus
        stim_row_t row;

        // An empty table grants nothing; a zero-size request is treated as size one and matches an occupied entry.
        dir_rows.push_back(rq_known(1, 1, 1'b0, 0));
        dir_rows.push_back(rq_known(0, 2, 1'b0, 0));
        dir_rows.push_back(ld(0, 16'hFFFF));
        dir_rows.push_back(ld(15, 1));
        dir_rows.push_back(ld(7, 16'h00FF));
        dir_rows.push_back(rq_known(0, 3, 1'b1, 0));
        dir_rows.push_back(rq_known(16'hFFFF, 4, 1'b0, 0));
        dir_rows.push_back(rq_known(1, 5, 1'b1, 7));
        dir_rows.push_back(rq_known(1, 6, 1'b1, 15));
        dir_rows.push_back(wr(fpba_pkg::REG_FIT_MODE, int'(fpba_pkg::MODE_BEST_FIT)));
        dir_rows.push_back(ld(2, 300));
        dir_rows.push_back(ld(5, 200));
        dir_rows.push_back(ld(9, 200));
        dir_rows.push_back(ld(11, 500));
        dir_rows.push_back(rq(150));
        dir_rows.push_back(wr(fpba_pkg::REG_FIT_MODE, int'(fpba_pkg::MODE_WORST_FIT)));
        dir_rows.push_back(rq(100));
        dir_rows.push_back(rq(100));
        dir_rows.push_back(wr(fpba_pkg::REG_BLOCK_COUNT, 0));
        dir_rows.push_back(rq_known(1, 10, 1'b0, 0));
        // The unused mode code acts as first fit, and a count above the table searches it all.
        dir_rows.push_back(wr(fpba_pkg::REG_FIT_MODE, 8'hFF));
        dir_rows.push_back(wr(fpba_pkg::REG_BLOCK_COUNT, 8'hFF));
        dir_rows.push_back(rq(1));
        dir_rows.push_back(wr(REG_SPARE_LO, 8'h5A));
        dir_rows.push_back(wr(REG_SPARE_HI, 8'hA5));
        dir_rows.push_back(rq(1));

        reset_table();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG)
            begin
                settle();
                write_reg(row.reg_idx, row.reg_data);
            end
            else
            begin
                offer_word(row.cmd, row.slot, row.size, row.typed, row.typed_res);
            end
        end

        run_phase({6'd0, fpba_pkg::MODE_FIRST_FIT}, 8'hF0, 0, 0, 0, 110);
        run_phase({6'($urandom), fpba_pkg::MODE_BEST_FIT}, 8'h10, 82, 0, 0, 110);
        run_phase({6'($urandom), fpba_pkg::MODE_WORST_FIT}, 8'h01, 0, 82, 0, 110);
        run_phase(8'hFF, 8'hFF, 8, 8, 0, 110);
        settle();
        write_reg(REG_SPARE_LO, fpba_pkg::CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_HI, fpba_pkg::CFG_DATA_W'($urandom));
        run_phase({6'($urandom), fpba_pkg::MODE_BEST_FIT}, 8'h00, 0, 0, 0, 40);
        run_phase({6'($urandom), fpba_pkg::MODE_WORST_FIT},
                  {3'($urandom), 5'($urandom_range(1, 16))}, 0, 0, 400, 140);

        settle();
        if (mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
